// File: rtl/positional_insert_delete_list_defines.svh
// Assertion macros for the positional insert/delete list checker.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef POSITIONAL_INSERT_DELETE_LIST_DEFINES_SVH
`define POSITIONAL_INSERT_DELETE_LIST_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define PIDL_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pidl check failed: same-cycle property");

// Next-cycle implication, disabled while in reset.
`define PIDL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pidl check failed: next-cycle property");

`endif

// File: rtl/pidl_pkg.sv
// Shared types and constants of the positional insert/delete list.
// No dependencies; every other file of the block but the defines header imports this package.
package pidl_pkg;

    localparam int DEFAULT_CAPACITY   = 16;
    localparam int DEFAULT_DATA_WIDTH = 32;

    localparam int REQ_TYPE_WIDTH = 2;
    localparam int POS_WIDTH      = 5;
    localparam int VALUE_WIDTH    = 32;
    localparam int STATUS_WIDTH   = 2;
    localparam int COUNT_WIDTH    = 5;

    // Request codes
    localparam logic [REQ_TYPE_WIDTH-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_TYPE_WIDTH-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_TYPE_WIDTH-1:0] REQ_READ   = 2'd2;

    // Status codes
    localparam logic [STATUS_WIDTH-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_DELETE,
        OP_READ
    } pidl_op_t;

    // Controller to datapath
    typedef struct packed {
        logic     load;   // capture a new result
        pidl_op_t op;     // list operation to carry out
    } pidl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pos_le_count;
        logic pos_lt_count;
        logic full;
    } pidl_stat_t;

endpackage

// File: rtl/pidl_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on pidl_pkg for the payload widths.
interface pidl_req_if;
    import pidl_pkg::*;

    logic                             valid;
    logic                             ready;
    logic        [REQ_TYPE_WIDTH-1:0] req_type;
    logic        [POS_WIDTH-1:0]      position;
    logic signed [VALUE_WIDTH-1:0]    value;

    modport source (output valid, req_type, position, value, input ready);
    modport sink   (input valid, req_type, position, value, output ready);
endinterface

interface pidl_rsp_if;
    import pidl_pkg::*;

    logic                           valid;
    logic                           ready;
    logic        [STATUS_WIDTH-1:0] status;
    logic        [COUNT_WIDTH-1:0]  count;
    logic signed [VALUE_WIDTH-1:0]  read_value;

    modport source (output valid, status, count, read_value, input ready);
    modport sink   (input valid, status, count, read_value, output ready);
endinterface

// File: rtl/pidl_ctrl.sv
// Controller of the positional insert/delete list: handshake, request decode, status.
// Depends on pidl_pkg; drives commands into pidl_dp.
module pidl_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [pidl_pkg::REQ_TYPE_WIDTH-1:0] req_type,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [pidl_pkg::STATUS_WIDTH-1:0]   status,
    input  pidl_pkg::pidl_stat_t                dp_stat,
    output pidl_pkg::pidl_cmd_t                 cmd
);
    import pidl_pkg::*;

    typedef enum logic {
        S_EMPTY,
        S_HOLD
    } state_t;

    state_t                  state_reg, state_next;
    logic [STATUS_WIDTH-1:0] status_reg, status_next;
    logic                    accept;

    assign in_ready  = (state_reg == S_EMPTY) || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = (state_reg == S_HOLD);
    assign status    = status_reg;

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd.load    = accept;
        cmd.op      = OP_NONE;
        if (accept)
        begin
            state_next = S_HOLD;
            unique case (req_type)
                REQ_INSERT:
                begin
                    if (!dp_stat.pos_le_count)
                        status_next = ST_RANGE;
                    else if (dp_stat.full)
                        status_next = ST_FULL;
                    else
                    begin
                        status_next = ST_DONE;
                        cmd.op      = OP_INSERT;
                    end
                end
                REQ_DELETE:
                begin
                    status_next = dp_stat.pos_lt_count ? ST_DONE : ST_RANGE;
                    cmd.op      = dp_stat.pos_lt_count ? OP_DELETE : OP_NONE;
                end
                REQ_READ:
                begin
                    status_next = dp_stat.pos_lt_count ? ST_DONE : ST_RANGE;
                    cmd.op      = dp_stat.pos_lt_count ? OP_READ : OP_NONE;
                end
                default:
                    status_next = ST_RANGE;
            endcase
        end
        else if (out_ready)
            state_next = S_EMPTY;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_EMPTY;
            status_reg <= ST_DONE;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

endmodule

// File: rtl/pidl_dp.sv
// Datapath of the positional insert/delete list: shifting entry cells, count, read port.
// Depends on pidl_pkg; commanded by pidl_ctrl.
module pidl_dp #(
    parameter int CAPACITY   = pidl_pkg::DEFAULT_CAPACITY,
    parameter int DATA_WIDTH = pidl_pkg::DEFAULT_DATA_WIDTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic        [pidl_pkg::POS_WIDTH-1:0]   position,
    input  logic signed [pidl_pkg::VALUE_WIDTH-1:0] value,
    input  pidl_pkg::pidl_cmd_t                     cmd,
    output pidl_pkg::pidl_stat_t                    dp_stat,
    output logic        [pidl_pkg::COUNT_WIDTH-1:0] count,
    output logic signed [pidl_pkg::VALUE_WIDTH-1:0] read_value
);
    import pidl_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CW > POS_WIDTH) ? CW : POS_WIDTH;

    logic signed [DATA_WIDTH-1:0]  entries_reg [CAPACITY];
    logic        [CW-1:0]          count_reg, count_next;
    logic signed [VALUE_WIDTH-1:0] rd_reg, rd_next;
    logic        [CMP_W-1:0]       pos_ext, cnt_ext;
    logic        [IDX_W-1:0]       pos_idx;
    logic signed [DATA_WIDTH-1:0]  new_word;

    assign pos_ext  = CMP_W'(position);
    assign cnt_ext  = CMP_W'(count_reg);
    assign pos_idx  = pos_ext[IDX_W-1:0];
    assign new_word = DATA_WIDTH'(value);

    assign dp_stat.pos_le_count = (pos_ext <= cnt_ext);
    assign dp_stat.pos_lt_count = (pos_ext < cnt_ext);
    assign dp_stat.full         = (count_reg == CW'(CAPACITY));

    // One register cell per entry; each sees only its two neighbors.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam logic [CMP_W-1:0] CELL = CMP_W'(i);
        logic signed [DATA_WIDTH-1:0] lower, upper;

        if (i == 0)
        begin : g_first
            assign lower = '0;
        end
        else
        begin : g_mid_lo
            assign lower = entries_reg[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign upper = '0;
        end
        else
        begin : g_mid_hi
            assign upper = entries_reg[i+1];
        end

        always_ff @(posedge clk)
        begin
            unique case (cmd.op)
                OP_INSERT:
                begin
                    if (CELL == pos_ext)
                        entries_reg[i] <= new_word;
                    else if (CELL > pos_ext)
                        entries_reg[i] <= lower;
                end
                OP_DELETE:
                begin
                    if (CELL >= pos_ext)
                        entries_reg[i] <= upper;
                end
                OP_NONE, OP_READ:
                    ;
            endcase
        end
    end

    always_comb
    begin
        count_next = count_reg;
        unique case (cmd.op)
            OP_INSERT: count_next = count_reg + CW'(1);
            OP_DELETE: count_next = count_reg - CW'(1);
            OP_NONE, OP_READ: count_next = count_reg;
        endcase
        rd_next = (cmd.op == OP_READ) ? VALUE_WIDTH'(entries_reg[pos_idx]) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            rd_reg <= rd_next;
    end

    assign count      = COUNT_WIDTH'(count_reg);
    assign read_value = rd_reg;

endmodule

// File: rtl/positional_insert_delete_list.sv
// Positional insert/delete list, top level (pidl_ctrl + pidl_dp, pidl_if channels).
// An accepted request transaction has its response in the following cycle.
// Throughput: one request per cycle while the response is not stalled; the entry cells shift in parallel.
// The response sits in an output register; a new request is taken while it is consumed.
// Reset (rst_n, async low) empties the list and drops any pending response;
// entry cells are not cleared, since only entries below the count are ever read.
module positional_insert_delete_list #(
    parameter int CAPACITY   = pidl_pkg::DEFAULT_CAPACITY,
    parameter int DATA_WIDTH = pidl_pkg::DEFAULT_DATA_WIDTH
) (
    input  logic       clk,
    input  logic       rst_n,
    pidl_req_if.sink   req,
    pidl_rsp_if.source rsp
);
    import pidl_pkg::*;

    pidl_cmd_t  cmd;
    pidl_stat_t dp_stat;

    // Controller: accept a request transaction, pick the operation, hold the status.
    pidl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .req_type  (req.req_type),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (rsp.status),
        .dp_stat   (dp_stat),
        .cmd       (cmd)
    );

    // Datapath: shift the cells, advance the count, register the read value.
    pidl_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .position   (req.position),
        .value      (req.value),
        .cmd        (cmd),
        .dp_stat    (dp_stat),
        .count      (rsp.count),
        .read_value (rsp.read_value)
    );

endmodule

// File: rtl/pidl_checker.sv
// Port-level checks of the positional insert/delete list, bound to the top level.
// Depends on pidl_pkg and positional_insert_delete_list_defines.svh.
`include "positional_insert_delete_list_defines.svh"

module pidl_checker #(
    parameter int CAPACITY = pidl_pkg::DEFAULT_CAPACITY
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic [pidl_pkg::STATUS_WIDTH-1:0]    status,
    input logic [pidl_pkg::COUNT_WIDTH-1:0]     count,
    input logic signed [pidl_pkg::VALUE_WIDTH-1:0] read_value
);
    import pidl_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(CAPACITY);

    logic rsp_stall;

    assign rsp_stall = out_valid && !out_ready;

    // A stalled response holds valid and payload.
    `PIDL_ASSERT_NEXT(a_rsp_hold, rsp_stall, out_valid && $stable({status, count, read_value}))

    // Every accepted request yields a response in the next cycle.
    `PIDL_ASSERT_NEXT(a_req_to_rsp, in_valid && in_ready, out_valid)

    // With no response pending, a request is never stalled.
    `PIDL_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready)

    // A full status reports a count of exactly the capacity.
    `PIDL_ASSERT_SAME(a_full_count, out_valid && (status == ST_FULL), count == FULL_COUNT)

endmodule

bind positional_insert_delete_list pidl_checker #(
    .CAPACITY (CAPACITY)
) u_pidl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .status     (rsp.status),
    .count      (rsp.count),
    .read_value (rsp.read_value)
);
